>>> rtl/aest_pkg.sv
// Shared types and constants for the ECMA-48 control sequence tokenizer.
package aest_pkg;

    localparam int LEN_W          = 13;
    localparam int MAX_BUFFER_DEF = 4096;
    localparam int QDEPTH         = 2;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

    localparam logic [3:0] K_TEXT = 4'd0;
    localparam logic [3:0] K_C0   = 4'd1;
    localparam logic [3:0] K_C1   = 4'd2;
    localparam logic [3:0] K_ESC  = 4'd3;
    localparam logic [3:0] K_SS2  = 4'd4;
    localparam logic [3:0] K_SS3  = 4'd5;
    localparam logic [3:0] K_CSI  = 4'd6;
    localparam logic [3:0] K_DCS  = 4'd7;
    localparam logic [3:0] K_SOS  = 4'd8;
    localparam logic [3:0] K_OSC  = 4'd9;
    localparam logic [3:0] K_PM   = 4'd10;
    localparam logic [3:0] K_APC  = 4'd11;

    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    typedef enum logic [2:0] {
        ACT_ESC,
        ACT_EMIT,
        ACT_FIXED,
        ACT_CSI,
        ACT_STR
    } act_t;

    typedef struct packed {
        logic       is_end;
        act_t       idle_act;
        logic [3:0] idle_kind;
        logic [2:0] idle_exp;
        act_t       esc_act;
        logic [3:0] esc_kind;
        logic       csi_final;
        logic       str_term;
        logic       bslash;
        logic       is_esc;
    } cls_t;

endpackage

>>> rtl/ansi_escape_sequence_tokenizer_top.sv
// Top level of the ECMA-48 control sequence tokenizer.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_byte_value[7:0], s_stream_end
//  m_        out        m_valid / m_ready      m_token_kind[3:0], m_token_length[12:0],
//                                              m_status[1:0]
//  cfg_      in         cfg_valid / cfg_ready  cfg_data[12:0] (max_len)
//
// One byte per cycle sustained unless m_ stalls; the parser takes one queued byte per cycle.
// m_valid rises once the closing byte has passed through the queue and the output register.
// s_ready falls only while the two-entry queue is full; that happens while m_ stalls.
// Synchronous active-low reset; no clearing pass. cfg_ready is always high.
module ansi_escape_sequence_tokenizer_top #(
    parameter int MAX_BUFFER = aest_pkg::MAX_BUFFER_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_byte_value,
    input  logic                       s_stream_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [3:0]                 m_token_kind,
    output logic [aest_pkg::LEN_W-1:0] m_token_length,
    output logic [1:0]                 m_status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [aest_pkg::LEN_W-1:0] cfg_data
);
    import aest_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cls_t push_cls, pop_cls;

    assign cfg_ready = 1'b1;

    aest_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_stream_end (s_stream_end),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cls     (push_cls)
    );

    aest_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cls   (push_cls),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cls    (pop_cls)
    );

    aest_back #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cls        (pop_cls),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_length (m_token_length),
        .m_status       (m_status)
    );

endmodule

>>> rtl/aest_front.sv
// Front end: takes input bytes and classifies them for the parser.
module aest_front (
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_byte_value,
    input  logic         s_stream_end,
    output logic         push_valid,
    input  logic         push_ready,
    output aest_pkg::cls_t push_cls
);
    import aest_pkg::*;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_cls           = '0;
        push_cls.is_end    = s_stream_end;
        push_cls.idle_act  = ACT_EMIT;
        push_cls.idle_kind = K_TEXT;
        push_cls.idle_exp  = 3'd0;
        unique case (s_byte_value) inside
            8'h1B: begin
                push_cls.idle_act  = ACT_ESC;
                push_cls.idle_kind = K_ESC;
            end
            [8'h00:8'h1A], [8'h1C:8'h1F]: push_cls.idle_kind = K_C0;
            8'h8E: begin
                push_cls.idle_act  = ACT_FIXED;
                push_cls.idle_kind = K_SS2;
                push_cls.idle_exp  = 3'd1;
            end
            8'h8F: begin
                push_cls.idle_act  = ACT_FIXED;
                push_cls.idle_kind = K_SS3;
                push_cls.idle_exp  = 3'd1;
            end
            8'h9B: begin
                push_cls.idle_act  = ACT_CSI;
                push_cls.idle_kind = K_CSI;
            end
            8'h90: begin
                push_cls.idle_act  = ACT_STR;
                push_cls.idle_kind = K_DCS;
            end
            8'h98: begin
                push_cls.idle_act  = ACT_STR;
                push_cls.idle_kind = K_SOS;
            end
            8'h9D: begin
                push_cls.idle_act  = ACT_STR;
                push_cls.idle_kind = K_OSC;
            end
            8'h9E: begin
                push_cls.idle_act  = ACT_STR;
                push_cls.idle_kind = K_PM;
            end
            8'h9F: begin
                push_cls.idle_act  = ACT_STR;
                push_cls.idle_kind = K_APC;
            end
            [8'h80:8'h8D], [8'h91:8'h97], [8'h99:8'h9A], 8'h9C: push_cls.idle_kind = K_C1;
            [8'hC0:8'hDF]: begin
                push_cls.idle_act = ACT_FIXED;
                push_cls.idle_exp = 3'd1;
            end
            [8'hE0:8'hEF]: begin
                push_cls.idle_act = ACT_FIXED;
                push_cls.idle_exp = 3'd2;
            end
            [8'hF0:8'hF7]: begin
                push_cls.idle_act = ACT_FIXED;
                push_cls.idle_exp = 3'd3;
            end
            default: push_cls.idle_kind = K_TEXT;
        endcase

        push_cls.esc_act  = ACT_EMIT;
        push_cls.esc_kind = K_ESC;
        unique case (s_byte_value)
            8'h4E: begin
                push_cls.esc_act  = ACT_FIXED;
                push_cls.esc_kind = K_SS2;
            end
            8'h4F: begin
                push_cls.esc_act  = ACT_FIXED;
                push_cls.esc_kind = K_SS3;
            end
            8'h5B: begin
                push_cls.esc_act  = ACT_CSI;
                push_cls.esc_kind = K_CSI;
            end
            8'h50: begin
                push_cls.esc_act  = ACT_STR;
                push_cls.esc_kind = K_DCS;
            end
            8'h58: begin
                push_cls.esc_act  = ACT_STR;
                push_cls.esc_kind = K_SOS;
            end
            8'h5D: begin
                push_cls.esc_act  = ACT_STR;
                push_cls.esc_kind = K_OSC;
            end
            8'h5E: begin
                push_cls.esc_act  = ACT_STR;
                push_cls.esc_kind = K_PM;
            end
            8'h5F: begin
                push_cls.esc_act  = ACT_STR;
                push_cls.esc_kind = K_APC;
            end
            default: push_cls.esc_act = ACT_EMIT;
        endcase

        push_cls.csi_final = (s_byte_value >= 8'h40) && (s_byte_value <= 8'h7E);
        push_cls.str_term  = (s_byte_value == 8'h07) || (s_byte_value == 8'h9C);
        push_cls.bslash    = (s_byte_value == 8'h5C);
        push_cls.is_esc    = (s_byte_value == 8'h1B);
    end

endmodule

>>> rtl/aest_queue.sv
// Short queue of classified bytes between front end and parser.
module aest_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  aest_pkg::cls_t push_cls,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aest_pkg::cls_t pop_cls
);
    import aest_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);

    cls_t          mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cls    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/aest_back.sv
// Back end: token parser state machine, max_len register and output register.
module aest_back #(
    parameter int MAX_BUFFER = aest_pkg::MAX_BUFFER_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [aest_pkg::LEN_W-1:0] cfg_data,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  aest_pkg::cls_t            pop_cls,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [3:0]                m_token_kind,
    output logic [aest_pkg::LEN_W-1:0] m_token_length,
    output logic [1:0]                m_status
);
    import aest_pkg::*;

    localparam int LEN_MAX   = (1 << LEN_W) - 1;
    localparam int BUF_CLAMP = (MAX_BUFFER > LEN_MAX) ? LEN_MAX : MAX_BUFFER;
    localparam logic [LEN_W-1:0] LIM_CAP = LEN_W'(BUF_CLAMP);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_FIXED,
        PH_CSI,
        PH_STR
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       kind_reg, kind_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       exp_reg, exp_next;
    logic             pwe_reg, pwe_next;
    logic [LEN_W-1:0] max_len_reg;
    logic             m_valid_reg;
    logic [3:0]       kind_out_reg;
    logic [LEN_W-1:0] len_out_reg;
    logic [1:0]       st_out_reg;

    logic             do_pop, emit;
    logic [3:0]       e_kind;
    logic [LEN_W-1:0] e_len, c_inc, lim;
    logic [1:0]       e_st;

    assign pop_ready      = !m_valid_reg || m_ready;
    assign do_pop         = pop_valid && pop_ready;
    assign lim            = (max_len_reg > LIM_CAP) ? LIM_CAP : max_len_reg;
    assign c_inc          = cnt_reg + 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_token_kind   = kind_out_reg;
    assign m_token_length = len_out_reg;
    assign m_status       = st_out_reg;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        pwe_next   = pwe_reg;
        emit       = 1'b0;
        e_kind     = kind_reg;
        e_len      = cnt_reg;
        e_st       = ST_COMPLETE;
        if (do_pop) begin
            if (pop_cls.is_end) begin
                emit   = (phase_reg != PH_IDLE);
                e_st   = ST_INCOMPLETE;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        cnt_next = LEN_W'(1);
                        unique case (pop_cls.idle_act)
                            ACT_ESC: begin
                                kind_next  = K_ESC;
                                phase_next = PH_ESC;
                            end
                            ACT_EMIT: begin
                                emit   = 1'b1;
                                e_kind = pop_cls.idle_kind;
                                e_len  = LEN_W'(1);
                            end
                            ACT_FIXED: begin
                                kind_next  = pop_cls.idle_kind;
                                phase_next = PH_FIXED;
                                exp_next   = pop_cls.idle_exp;
                            end
                            ACT_CSI, ACT_STR: begin
                                kind_next  = pop_cls.idle_kind;
                                phase_next = (pop_cls.idle_act == ACT_CSI) ? PH_CSI : PH_STR;
                                pwe_next   = 1'b0;
                                emit       = (LEN_W'(1) >= lim);
                                e_kind     = pop_cls.idle_kind;
                                e_len      = LEN_W'(1);
                                e_st       = ST_TOO_LONG;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                    PH_ESC: begin
                        cnt_next = LEN_W'(2);
                        unique case (pop_cls.esc_act)
                            ACT_FIXED: begin
                                kind_next  = pop_cls.esc_kind;
                                phase_next = PH_FIXED;
                                exp_next   = 3'd1;
                            end
                            ACT_CSI, ACT_STR: begin
                                kind_next  = pop_cls.esc_kind;
                                phase_next = (pop_cls.esc_act == ACT_CSI) ? PH_CSI : PH_STR;
                                pwe_next   = 1'b0;
                                emit       = (LEN_W'(2) >= lim);
                                e_kind     = pop_cls.esc_kind;
                                e_len      = LEN_W'(2);
                                e_st       = ST_TOO_LONG;
                            end
                            default: begin
                                emit   = 1'b1;
                                e_kind = K_ESC;
                                e_len  = LEN_W'(2);
                            end
                        endcase
                    end
                    PH_FIXED: begin
                        cnt_next = c_inc;
                        e_len    = c_inc;
                        if (exp_reg <= 3'd1) begin
                            emit = 1'b1;
                        end else begin
                            exp_next = exp_reg - 1'b1;
                        end
                    end
                    PH_CSI: begin
                        cnt_next = c_inc;
                        e_len    = c_inc;
                        if (pop_cls.csi_final) begin
                            emit = 1'b1;
                        end else if (c_inc >= lim) begin
                            emit = 1'b1;
                            e_st = ST_TOO_LONG;
                        end
                    end
                    PH_STR: begin
                        cnt_next = c_inc;
                        e_len    = c_inc;
                        pwe_next = pop_cls.is_esc;
                        if (pop_cls.str_term || (pwe_reg && pop_cls.bslash)) begin
                            emit = 1'b1;
                        end else if (c_inc >= lim) begin
                            emit = 1'b1;
                            e_st = ST_TOO_LONG;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            if (emit) begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
                exp_next   = '0;
                pwe_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            kind_reg    <= K_TEXT;
            cnt_reg     <= '0;
            exp_reg     <= '0;
            pwe_reg     <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
            pwe_reg   <= pwe_next;
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end
            if (do_pop && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (do_pop && emit) begin
            kind_out_reg <= e_kind;
            len_out_reg  <= e_len;
            st_out_reg   <= e_st;
        end
    end

endmodule

>>> rtl/aest_checker.sv
// Port-level assertions for the tokenizer top level, with bind.
module aest_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [3:0]                 m_token_kind,
    input logic [aest_pkg::LEN_W-1:0] m_token_length,
    input logic [1:0]                 m_status
);
    import aest_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_token_length) && $stable(m_status))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= K_APC)
        else $error("bad token kind");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("bad status");

    a_single_ctl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == K_C0 || m_token_kind == K_C1)
            |-> m_token_length == LEN_W'(1) && m_status == ST_COMPLETE)
        else $error("control token not single byte");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_length != '0)
        else $error("zero length token");

endmodule

bind ansi_escape_sequence_tokenizer_top aest_checker u_aest_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_length (m_token_length),
    .m_status       (m_status)
);
